[hw/rtl/oale_pkg.sv]
package oale_pkg;

  localparam int CAPACITY_DEF   = 16;
  localparam int ENTRY_BITS_DEF = 64;

  localparam int ACTION_W   = 2;
  localparam int POSITION_W = 5;
  localparam int VALUE_W    = 64;
  localparam int STATUS_W   = 2;
  localparam int FOUND_W    = 4;
  localparam int COUNT_W    = 5;

  typedef enum logic [ACTION_W-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_FIND   = 2'd3
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_MISS  = 2'd3
  } status_e;

  typedef struct packed {
    action_e                 action;
    logic [POSITION_W-1:0]   position;
    logic [VALUE_W-1:0]      entry_value;
  } item_t;

  typedef struct packed {
    status_e                 status;
    logic [VALUE_W-1:0]      read_value;
    logic [FOUND_W-1:0]      found_index;
    logic [COUNT_W-1:0]      entry_count;
  } result_t;

  typedef struct packed {
    logic load;
    logic run;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic run_done;
  } sts_t;

endpackage

[hw/rtl/oale_ram.sv]
module oale_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/oale_ctrl.sv]
module oale_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  oale_pkg::sts_t sts_i,
  output oale_pkg::cmd_t cmd_o,
  output logic           busy_o,
  output logic           done_o
);

  import oale_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RUN  = 2'd1;
  localparam logic [1:0] S_TAIL = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state_d, state_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_RUN;
        end
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.run_done) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        cmd_o.commit = 1'b1;
        state_d      = S_DONE;
      end
      S_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = (state_q == S_DONE);

endmodule

[hw/rtl/oale_dp.sv]
module oale_dp #(
  parameter int CAPACITY   = 16,
  parameter int ENTRY_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  oale_pkg::cmd_t    cmd_i,
  input  oale_pkg::item_t   item_i,
  output oale_pkg::sts_t    sts_o,
  output oale_pkg::result_t result_o
);

  import oale_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POSITION_W) ? CNT_W : POSITION_W;

  action_e               op_d, op_q;
  logic [POSITION_W-1:0] pos_d, pos_q;
  logic [ENTRY_BITS-1:0] key_d, key_q;
  logic [CNT_W-1:0]      cnt_d, cnt_q;
  logic [CNT_W-1:0]      rem_d, rem_q;
  logic [IDX_W-1:0]      ptr_d, ptr_q;
  logic                  pend_d, pend_q;
  logic [IDX_W-1:0]      pend_addr_d, pend_addr_q;
  status_e               status_d, status_q;
  logic [ENTRY_BITS-1:0] rdval_d, rdval_q;
  logic [IDX_W-1:0]      fidx_d, fidx_q;
  result_t               res_d, res_q;

  logic [CMP_W-1:0]      in_pos, cur_cnt;
  logic                  issue, match, shift_wr, ins_ok;
  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [ENTRY_BITS-1:0] ram_wdata;
  logic [ENTRY_BITS-1:0] ram_rdata;

  assign in_pos  = CMP_W'(item_i.position);
  assign cur_cnt = CMP_W'(cnt_q);

  assign issue    = cmd_i.run && (rem_q != '0);
  assign match    = cmd_i.run && pend_q && (op_q == ACT_FIND) && (ram_rdata == key_q);
  assign shift_wr = cmd_i.run && pend_q && ((op_q == ACT_INSERT) || (op_q == ACT_REMOVE));
  assign ins_ok   = cmd_i.commit && (op_q == ACT_INSERT) && (status_q == ST_OK);

  always_comb begin
    op_d        = op_q;
    pos_d       = pos_q;
    key_d       = key_q;
    cnt_d       = cnt_q;
    rem_d       = rem_q;
    ptr_d       = ptr_q;
    pend_d      = pend_q;
    pend_addr_d = pend_addr_q;
    status_d    = status_q;
    rdval_d     = rdval_q;
    fidx_d      = fidx_q;
    res_d       = res_q;

    if (cmd_i.load) begin
      op_d    = item_i.action;
      pos_d   = item_i.position;
      key_d   = item_i.entry_value[ENTRY_BITS-1:0];
      rdval_d = '0;
      fidx_d  = '0;
      pend_d  = 1'b0;
      rem_d   = '0;
      ptr_d   = '0;
      case (item_i.action)
        ACT_INSERT: begin
          if (cnt_q == CNT_W'(CAPACITY)) begin
            status_d = ST_FULL;
          end else if (in_pos > cur_cnt) begin
            status_d = ST_RANGE;
          end else begin
            status_d = ST_OK;
            rem_d    = CNT_W'(cur_cnt - in_pos);
            ptr_d    = IDX_W'(cnt_q - CNT_W'(1));
          end
        end
        ACT_REMOVE: begin
          if (in_pos >= cur_cnt) begin
            status_d = ST_RANGE;
          end else begin
            status_d = ST_OK;
            rem_d    = CNT_W'(cur_cnt - in_pos - CMP_W'(1));
            ptr_d    = IDX_W'(in_pos + CMP_W'(1));
          end
        end
        ACT_READ: begin
          if (in_pos >= cur_cnt) begin
            status_d = ST_RANGE;
          end else begin
            status_d = ST_OK;
            rem_d    = CNT_W'(1);
            ptr_d    = IDX_W'(in_pos);
          end
        end
        default: begin
          status_d = ST_MISS;
          rem_d    = cnt_q;
        end
      endcase
    end

    if (cmd_i.run) begin
      pend_d = issue;
      if (issue) begin
        rem_d       = rem_q - CNT_W'(1);
        pend_addr_d = ptr_q;
        ptr_d       = (op_q == ACT_INSERT) ? ptr_q - IDX_W'(1) : ptr_q + IDX_W'(1);
      end
      if (pend_q && (op_q == ACT_READ)) begin
        rdval_d = ram_rdata;
      end
      if (match) begin
        rem_d    = '0;
        pend_d   = 1'b0;
        status_d = ST_OK;
        fidx_d   = pend_addr_q;
      end
    end

    if (cmd_i.commit) begin
      if (status_q == ST_OK) begin
        if (op_q == ACT_INSERT) begin
          cnt_d = cnt_q + CNT_W'(1);
        end else if (op_q == ACT_REMOVE) begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      res_d.status      = status_q;
      res_d.read_value  = VALUE_W'(rdval_q);
      res_d.found_index = FOUND_W'(fidx_q);
      res_d.entry_count = COUNT_W'(cnt_d);
    end
  end

  always_comb begin
    ram_we    = shift_wr || ins_ok;
    ram_wdata = ram_rdata;
    if (cmd_i.commit) begin
      ram_waddr = IDX_W'(pos_q);
      ram_wdata = key_q;
    end else if (op_q == ACT_INSERT) begin
      ram_waddr = pend_addr_q + IDX_W'(1);
    end else begin
      ram_waddr = pend_addr_q - IDX_W'(1);
    end
  end

  oale_ram #(
    .WIDTH (ENTRY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ptr_q),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      rem_q  <= '0;
      pend_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      rem_q  <= rem_d;
      pend_q <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q        <= op_d;
    pos_q       <= pos_d;
    key_q       <= key_d;
    ptr_q       <= ptr_d;
    pend_addr_q <= pend_addr_d;
    status_q    <= status_d;
    rdval_q     <= rdval_d;
    fidx_q      <= fidx_d;
    res_q       <= res_d;
  end

  assign sts_o.run_done = (rem_q == '0) && !pend_q;
  assign result_o       = res_q;

endmodule

[hw/rtl/ordered_array_list_engine_core.sv]
// ordered list of up to CAPACITY entries kept in a simple dual-port ram (one write and one
// registered read per cycle, at separate addresses). an item is taken when start is high and
// busy is low; its result shows on result_o for one cycle with done_o high and must be taken
// then, there is no stall. every entry that an insert moves, a remove moves, a read returns or
// a find compares takes one ram read; an empty find or a rejected item reads none. insert
// reads count-position entries, remove count-position-1, read one, find up to the first
// match. busy drops in the cycle after done_o. entry storage is not cleared at reset.
module ordered_array_list_engine_core #(
  parameter int CAPACITY   = oale_pkg::CAPACITY_DEF,
  parameter int ENTRY_BITS = oale_pkg::ENTRY_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  oale_pkg::item_t   item_i,
  output logic              done_o,
  output oale_pkg::result_t result_o
);

  import oale_pkg::*;

  cmd_t cmd;
  sts_t sts;

  oale_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy),
    .done_o  (done_o)
  );

  oale_dp #(
    .CAPACITY   (CAPACITY),
    .ENTRY_BITS (ENTRY_BITS)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item_i),
    .sts_o    (sts),
    .result_o (result_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result strobe outside busy");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy)
    else $error("busy held after result");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (result_o.status != ST_OK)) |->
      ((result_o.read_value == '0) && (result_o.found_index == '0)))
    else $error("failed item carries data");

endmodule
